FILE: hdl/spanning_tree_count_mod_prime_unit_defines.svh
// Assertion macros shared by the spanning tree counter RTL
`ifndef SPANNING_TREE_COUNT_MOD_PRIME_UNIT_DEFINES_SVH
`define SPANNING_TREE_COUNT_MOD_PRIME_UNIT_DEFINES_SVH

// clocked check, switched off while reset is held
`define STC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also holds during reset
`define STC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: hdl/stc_pkg.sv
// Shared constants, types and sequencer states of the spanning tree counter
package stc_pkg;

    localparam int VAL_W = 30;
    localparam logic [VAL_W-1:0] PRIME_P   = 30'd998244353;
    localparam logic [VAL_W-1:0] P_MINUS_2 = 30'd998244351;
    localparam logic [VAL_W-1:0] P_MINUS_1 = 30'd998244352;
    localparam int MAX_VERTICES_DEF = 64;

    localparam logic OP_EDGE    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // request to the modular multiplier
    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } mm_req_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_E_RD,
        ST_E_WR,
        ST_C_COL,
        ST_P_RD,
        ST_P_CHK,
        ST_S_RA,
        ST_S_RB,
        ST_S_WA,
        ST_S_WB,
        ST_V_RD,
        ST_V_CAP,
        ST_V_MUL,
        ST_X_MUL,
        ST_X_MW,
        ST_X_SQ,
        ST_X_SW,
        ST_R_CHK,
        ST_R_RD,
        ST_R_CAP,
        ST_R_MUL,
        ST_J_RC,
        ST_J_CAP,
        ST_J_MUL,
        ST_J_RR,
        ST_J_WR,
        ST_RESULT
    } stc_state_t;

endpackage

FILE: hdl/stc_lap_ram.sv
// Single-port Laplacian store with registered read data
module stc_lap_ram
    import stc_pkg::*;
#(
    parameter int DEPTH = MAX_VERTICES_DEF * MAX_VERTICES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [VAL_W-1:0] wdata,
    output logic [VAL_W-1:0] rdata
);

    logic [VAL_W-1:0] mem [DEPTH];

    // read every cycle, old data on a write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: hdl/stc_mulmod.sv
// Bit-serial multiplier modulo P, one multiplier bit per cycle
module stc_mulmod
    import stc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  mm_req_t          req,
    output logic             done,
    output logic [VAL_W-1:0] res
);

    localparam int CNT_W = $clog2(VAL_W + 1);

    logic [VAL_W-1:0] acc_reg, acc_next;
    logic [VAL_W-1:0] a_reg, a_next;
    logic [VAL_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [VAL_W:0] dbl, dbl_red, sum, sum_red;

    // acc = 2*acc + bit*a, the doubling and the sum each reduced by one compare and subtract
    always_comb begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, PRIME_P}) ? dbl - {1'b0, PRIME_P} : dbl;
        sum     = dbl_red + (b_reg[VAL_W-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= {1'b0, PRIME_P}) ? sum - {1'b0, PRIME_P} : sum;
    end

    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            acc_next  = '0;
            a_next    = req.a;
            b_next    = req.b;
            cnt_next  = CNT_W'(VAL_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = sum_red[VAL_W-1:0];
            b_next   = {b_reg[VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign res  = acc_reg;

endmodule

FILE: hdl/spanning_tree_count_mod_prime_unit.sv
// Spanning tree counter mod 998244353: Laplacian store, sequencer and output register
// Edge item: four read-modify-write passes over the single-port store.
// Compute item: Gaussian elimination over the store for dimension d, each product
//   from the bit-serial multiplier and each pivot inverse by exponentiation to P-2.
//   The count is registered and held until taken.
// Reset and every compute item start a clearing pass over all MAX_VERTICES^2 cells
//   (4096 at default) during which no item is taken; vertex_count resets to 1.
module spanning_tree_count_mod_prime_unit
    import stc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: vertex_count
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] end_a, [11:6] end_b, [15:12] zero
    input  logic [0:0]  s_tuser,   // [0] op
    // result requests
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [29:0] tree_count, [31:30] zero
);

`include "spanning_tree_count_mod_prime_unit_defines.svh"

    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_VERTICES);
    localparam int VW    = ($clog2(MAX_VERTICES + 1) > 7) ? $clog2(MAX_VERTICES + 1) : 7;
    localparam int CW    = (IW > 6) ? IW : 6;

    stc_state_t state_reg, state_next;

    logic [6:0]       vertex_count_reg;
    logic [1:0]       step_reg, step_next;
    logic [5:0]       ea_reg, ea_next, eb_reg, eb_next;
    logic [IW-1:0]    d_reg, d_next;
    logic [IW-1:0]    col_reg, col_next, piv_reg, piv_next;
    logic [IW-1:0]    row_reg, row_next, j_reg, j_next;
    logic [VAL_W-1:0] tmp_reg, tmp_next;
    logic [VAL_W-1:0] prod_reg, prod_next;
    logic [VAL_W-1:0] acc_reg, acc_next;
    logic [VAL_W-1:0] base_reg, base_next;
    logic [4:0]       ebit_reg, ebit_next;
    logic [VAL_W-1:0] f_reg, f_next;
    logic [VAL_W-1:0] sub_reg, sub_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic             m_tvalid_reg;
    logic [VAL_W-1:0] m_data_reg;

    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [VAL_W-1:0] mem_wdata, mem_rdata;
    mm_req_t          mm_req;
    logic             mm_done;
    logic [VAL_W-1:0] mm_res;

    logic [VW-1:0]    vc_ext, vc_sat;
    logic [IW-1:0]    dim;
    logic             in_acc, u_in, v_in, e_en, out_load;
    logic [IW-1:0]    u_idx, v_idx;
    logic [AW-1:0]    e_addr;
    logic [VAL_W-1:0] e_new, neg_prod, upd_val;
    logic [VAL_W:0]   upd_sum;

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r,
                                                 input logic [IW-1:0] c);
        cell_addr = AW'(r) * AW'(MAX_VERTICES) + AW'(c);
    endfunction

    // storage and multiplier
    stc_lap_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    stc_mulmod u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .done    (mm_done),
        .res     (mm_res)
    );

    // matrix dimension from the saturated vertex count
    always_comb begin
        vc_ext = VW'(vertex_count_reg);
        vc_sat = (vc_ext > VW'(MAX_VERTICES)) ? VW'(MAX_VERTICES) : vc_ext;
        dim    = (vc_sat == '0) ? '0 : IW'(vc_sat - VW'(1));
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_RESULT) && (!m_tvalid_reg || m_tready);

    // edge update helpers
    always_comb begin
        u_in  = CW'(ea_reg) < CW'(d_reg);
        v_in  = CW'(eb_reg) < CW'(d_reg);
        u_idx = IW'(ea_reg);
        v_idx = IW'(eb_reg);
        case (step_reg)
            2'd0:    begin e_addr = cell_addr(u_idx, u_idx); e_en = u_in; end
            2'd1:    begin e_addr = cell_addr(v_idx, v_idx); e_en = v_in; end
            2'd2:    begin e_addr = cell_addr(u_idx, v_idx); e_en = u_in && v_in; end
            default: begin e_addr = cell_addr(v_idx, u_idx); e_en = u_in && v_in; end
        endcase
        if (!step_reg[1]) begin
            e_new = (mem_rdata == P_MINUS_1) ? '0 : mem_rdata + VAL_W'(1);
        end else begin
            e_new = (mem_rdata == '0) ? P_MINUS_1 : mem_rdata - VAL_W'(1);
        end
        neg_prod = (prod_reg == '0) ? '0 : PRIME_P - prod_reg;
        upd_sum  = {1'b0, mem_rdata} + {1'b0, PRIME_P} - {1'b0, sub_reg};
        upd_val  = (mem_rdata >= sub_reg) ? mem_rdata - sub_reg : upd_sum[VAL_W-1:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser[0] == OP_COMPUTE) begin
                        state_next = ST_C_COL;
                    end else if (s_tdata[5:0] != s_tdata[11:6]) begin
                        state_next = ST_E_RD;
                    end
                end
            end
            ST_E_RD:   state_next = ST_E_WR;
            ST_E_WR:   state_next = (step_reg == 2'd3) ? ST_IDLE : ST_E_RD;
            ST_C_COL:  state_next = (col_reg == d_reg) ? ST_RESULT : ST_P_RD;
            ST_P_RD:   state_next = ST_P_CHK;
            ST_P_CHK: begin
                if (mem_rdata != '0) begin
                    state_next = (piv_reg == col_reg) ? ST_V_RD : ST_S_RA;
                end else if (piv_reg + IW'(1) == d_reg) begin
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_P_RD;
                end
            end
            ST_S_RA:   state_next = ST_S_RB;
            ST_S_RB:   state_next = ST_S_WA;
            ST_S_WA:   state_next = ST_S_WB;
            ST_S_WB:   state_next = (j_reg + IW'(1) == d_reg) ? ST_V_RD : ST_S_RA;
            ST_V_RD:   state_next = ST_V_CAP;
            ST_V_CAP:  state_next = ST_V_MUL;
            ST_V_MUL:  if (mm_done) state_next = ST_X_MUL;
            ST_X_MUL:  state_next = ST_X_MW;
            ST_X_MW:   if (mm_done) state_next = ST_X_SQ;
            ST_X_SQ:   state_next = ST_X_SW;
            ST_X_SW: begin
                if (mm_done) state_next = (ebit_reg == 5'd29) ? ST_R_CHK : ST_X_MUL;
            end
            ST_R_CHK:  state_next = (row_reg == d_reg) ? ST_C_COL : ST_R_RD;
            ST_R_RD:   state_next = ST_R_CAP;
            ST_R_CAP:  state_next = ST_R_MUL;
            ST_R_MUL:  if (mm_done) state_next = ST_J_RC;
            ST_J_RC:   state_next = ST_J_CAP;
            ST_J_CAP:  state_next = ST_J_MUL;
            ST_J_MUL:  if (mm_done) state_next = ST_J_RR;
            ST_J_RR:   state_next = ST_J_WR;
            ST_J_WR:   state_next = (j_reg + IW'(1) == d_reg) ? ST_R_CHK : ST_J_RC;
            ST_RESULT: if (out_load) state_next = ST_CLEAR;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // store and multiplier controls
    always_comb begin
        mem_we       = 1'b0;
        mem_addr     = '0;
        mem_wdata    = '0;
        mm_req.start = 1'b0;
        mm_req.a     = '0;
        mm_req.b     = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
            end
            ST_E_RD:  mem_addr = e_addr;
            ST_E_WR: begin
                mem_we    = e_en;
                mem_addr  = e_addr;
                mem_wdata = e_new;
            end
            ST_P_RD:  mem_addr = cell_addr(piv_reg, col_reg);
            ST_S_RA:  mem_addr = cell_addr(piv_reg, j_reg);
            ST_S_RB:  mem_addr = cell_addr(col_reg, j_reg);
            ST_S_WA: begin
                mem_we    = 1'b1;
                mem_addr  = cell_addr(piv_reg, j_reg);
                mem_wdata = mem_rdata;
            end
            ST_S_WB: begin
                mem_we    = 1'b1;
                mem_addr  = cell_addr(col_reg, j_reg);
                mem_wdata = tmp_reg;
            end
            ST_V_RD:  mem_addr = cell_addr(col_reg, col_reg);
            ST_V_CAP: begin
                mm_req.start = 1'b1;
                mm_req.a     = prod_reg;
                mm_req.b     = mem_rdata;
            end
            ST_X_MUL: begin
                mm_req.start = 1'b1;
                mm_req.a     = acc_reg;
                mm_req.b     = base_reg;
            end
            ST_X_SQ: begin
                mm_req.start = 1'b1;
                mm_req.a     = base_reg;
                mm_req.b     = base_reg;
            end
            ST_R_RD:  mem_addr = cell_addr(row_reg, col_reg);
            ST_R_CAP: begin
                mm_req.start = 1'b1;
                mm_req.a     = mem_rdata;
                mm_req.b     = acc_reg;
            end
            ST_J_RC:  mem_addr = cell_addr(col_reg, j_reg);
            ST_J_CAP: begin
                mm_req.start = 1'b1;
                mm_req.a     = f_reg;
                mm_req.b     = mem_rdata;
            end
            ST_J_RR:  mem_addr = cell_addr(row_reg, j_reg);
            ST_J_WR: begin
                mem_we    = 1'b1;
                mem_addr  = cell_addr(row_reg, j_reg);
                mem_wdata = upd_val;
            end
            default: ;
        endcase
    end

    // datapath registers
    always_comb begin
        step_next = step_reg;
        ea_next   = ea_reg;
        eb_next   = eb_reg;
        d_next    = d_reg;
        col_next  = col_reg;
        piv_next  = piv_reg;
        row_next  = row_reg;
        j_next    = j_reg;
        tmp_next  = tmp_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        base_next = base_reg;
        ebit_next = ebit_reg;
        f_next    = f_reg;
        sub_next  = sub_reg;
        clr_next  = clr_reg;
        case (state_reg)
            ST_CLEAR:  clr_next = clr_reg + AW'(1);
            ST_IDLE: begin
                step_next = 2'd0;
                ea_next   = s_tdata[5:0];
                eb_next   = s_tdata[11:6];
                d_next    = dim;
                col_next  = '0;
                prod_next = VAL_W'(1);
            end
            ST_E_WR:   step_next = step_reg + 2'd1;
            ST_C_COL:  piv_next = col_reg;
            ST_P_CHK: begin
                j_next = '0;
                if (mem_rdata != '0) begin
                    if (piv_reg != col_reg) prod_next = neg_prod;
                end else if (piv_reg + IW'(1) == d_reg) begin
                    prod_next = '0;
                end else begin
                    piv_next = piv_reg + IW'(1);
                end
            end
            ST_S_RB:   tmp_next = mem_rdata;
            ST_S_WB:   j_next = j_reg + IW'(1);
            ST_V_CAP:  base_next = mem_rdata;
            ST_V_MUL: begin
                if (mm_done) begin
                    prod_next = mm_res;
                    acc_next  = VAL_W'(1);
                    ebit_next = '0;
                end
            end
            ST_X_MW:   if (mm_done && P_MINUS_2[ebit_reg]) acc_next = mm_res;
            ST_X_SW: begin
                if (mm_done) begin
                    base_next = mm_res;
                    ebit_next = ebit_reg + 5'd1;
                    row_next  = col_reg + IW'(1);
                end
            end
            ST_R_CHK:  if (row_reg == d_reg) col_next = col_reg + IW'(1);
            ST_R_MUL: begin
                if (mm_done) begin
                    f_next = mm_res;
                    j_next = col_reg;
                end
            end
            ST_J_MUL:  if (mm_done) sub_next = mm_res;
            ST_J_WR: begin
                j_next = j_reg + IW'(1);
                if (j_reg + IW'(1) == d_reg) row_next = row_reg + IW'(1);
            end
            ST_RESULT: clr_next = '0;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            vertex_count_reg <= 7'd1;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_wr_en) vertex_count_reg <= cfg_wr_data;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (out_load) m_data_reg <= prod_reg;
        step_reg <= step_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        d_reg    <= d_next;
        col_reg  <= col_next;
        piv_reg  <= piv_next;
        row_reg  <= row_next;
        j_reg    <= j_next;
        tmp_reg  <= tmp_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        ebit_reg <= ebit_next;
        f_reg    <= f_next;
        sub_reg  <= sub_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_data_reg};

    // checks
    `STC_ASSERT(a_clear_blocks_input, (state_reg == ST_CLEAR) |-> !s_tready, "input taken during clearing pass")
    `STC_ASSERT(a_result_registered, out_load |=> m_tvalid_reg, "count not presented after load")
    `STC_ASSERT(a_mul_reduced, mm_done |-> (mm_res < PRIME_P), "multiplier result not reduced")
    `STC_ASSERT(a_store_write_reduced, mem_we |-> (mem_wdata < PRIME_P), "store written with unreduced value")

endmodule

FILE: tb/spanning_tree_count_mod_prime_unit_tb.sv
// Self-checking testbench for the spanning tree counter: directed graphs, then random loads
`timescale 1ns / 1ps

module spanning_tree_count_mod_prime_unit_tb;
    import stc_pkg::*;

    localparam int NV = 64;
    localparam longint unsigned PM = 64'd998244353;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [5:0] end_a, [11:6] end_b, [15:12] zero
    logic [0:0]  s_tuser = '0;   // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [29:0] tree_count, [31:30] zero

    // shadow of the Laplacian store and the vertex count
    logic [VAL_W-1:0] lap_shadow [NV*NV];
    logic [6:0]       vcount_shadow;
    logic [VAL_W-1:0] count_queue [$];
    int               errors = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;

    spanning_tree_count_mod_prime_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #6 aclk = ~aclk;

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int unsigned dim_now();
        int unsigned vc;
        vc = (vcount_shadow > NV) ? NV : vcount_shadow;
        return (vc == 0) ? 0 : vc - 1;
    endfunction

    function automatic logic [VAL_W-1:0] mulmod(logic [VAL_W-1:0] x, logic [VAL_W-1:0] y);
        longint unsigned prod;
        prod = (64'(x) * 64'(y)) % PM;
        return prod[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] invmod(logic [VAL_W-1:0] x);
        logic [VAL_W-1:0] acc;
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] ex;
        acc = 1;
        base = x;
        ex = P_MINUS_2;
        while (ex != 0) begin
            if (ex[0]) acc = mulmod(acc, base);
            base = mulmod(base, base);
            ex = ex >> 1;
        end
        return acc;
    endfunction

    // determinant of the top-left block, mod P
    function automatic logic [VAL_W-1:0] tree_count_det();
        int unsigned d;
        int unsigned piv;
        logic [VAL_W-1:0] prod;
        logic [VAL_W-1:0] inv;
        logic [VAL_W-1:0] f;
        logic [VAL_W-1:0] tmp;
        d = dim_now();
        prod = 1;
        for (int unsigned c = 0; c < d; c++) begin
            piv = c;
            while (piv < d && lap_shadow[piv*NV+c] == 0) piv++;
            if (piv == d) return '0;
            if (piv != c) begin
                for (int unsigned j = 0; j < d; j++) begin
                    tmp = lap_shadow[piv*NV+j];
                    lap_shadow[piv*NV+j] = lap_shadow[c*NV+j];
                    lap_shadow[c*NV+j] = tmp;
                end
                prod = (prod == 0) ? '0 : PRIME_P - prod;
            end
            prod = mulmod(prod, lap_shadow[c*NV+c]);
            inv = invmod(lap_shadow[c*NV+c]);
            for (int unsigned r = c + 1; r < d; r++) begin
                f = mulmod(lap_shadow[r*NV+c], inv);
                for (int unsigned j = c; j < d; j++) begin
                    tmp = mulmod(f, lap_shadow[c*NV+j]);
                    lap_shadow[r*NV+j] = VAL_W'((64'(lap_shadow[r*NV+j]) + PM - 64'(tmp)) % PM);
                end
            end
        end
        return prod;
    endfunction

    // apply one accepted request to the shadow state
    task automatic graph_apply(logic op, logic [5:0] a, logic [5:0] b);
        int unsigned d;
        d = dim_now();
        if (op == OP_COMPUTE) begin
            count_queue.push_back(tree_count_det());
            foreach (lap_shadow[i]) lap_shadow[i] = '0;
        end else if (a != b) begin
            if (a < d) lap_shadow[a*NV+a] = (lap_shadow[a*NV+a] == P_MINUS_1) ? '0 : lap_shadow[a*NV+a] + 1;
            if (b < d) lap_shadow[b*NV+b] = (lap_shadow[b*NV+b] == P_MINUS_1) ? '0 : lap_shadow[b*NV+b] + 1;
            if (a < d && b < d) begin
                lap_shadow[a*NV+b] = (lap_shadow[a*NV+b] == 0) ? P_MINUS_1 : lap_shadow[a*NV+b] - 1;
                lap_shadow[b*NV+a] = (lap_shadow[b*NV+a] == 0) ? P_MINUS_1 : lap_shadow[b*NV+a] - 1;
            end
        end
    endtask

    task automatic send_req(logic op, logic [5:0] a, logic [5:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        graph_apply(op, a, b);
    endtask

    task automatic send_edge(logic [5:0] a, logic [5:0] b);
        send_req(OP_EDGE, a, b);
    endtask

    task automatic send_compute();
        send_req(OP_COMPUTE, '0, '0);
    endtask

    // wait for all counts, then let a trailing edge request finish
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (count_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_vcount(logic [6:0] vc);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= vc;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        vcount_shadow = vc;
        @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (count_queue.size() == 0) begin
                $display("%0t: unexpected count, expected none, actual %0d", $time, m_tdata);
                errors++;
            end else begin
                if (m_tdata != {2'b0, count_queue[0]}) begin
                    $display("%0t: tree_count mismatch, expected %0d, actual %0d",
                             $time, count_queue[0], m_tdata);
                    errors++;
                end
                void'(count_queue.pop_front());
            end
        end
    end

    // empty and trivial matrices, dimension extremes
    task automatic test_trivial();
        set_vcount(7'd0);   send_compute(); drain();
        set_vcount(7'd1);   send_edge(6'd0, 6'd1); send_compute(); drain();
        set_vcount(7'd2);   send_compute(); drain();
        set_vcount(7'd2);   send_edge(6'd0, 6'd1); send_compute(); drain();
        // saturation above the vertex limit, vertex 0 isolated so no pivot in column 0
        set_vcount(7'd127); send_edge(6'd62, 6'd63); send_edge(6'd63, 6'd1);
        send_edge(6'd21, 6'd42); send_compute(); drain();
        set_vcount(7'd64);  send_edge(6'd63, 6'd62); send_compute(); drain();
    endtask

    // self-loops, out-of-range endpoints, small complete graphs
    task automatic test_graphs();
        set_vcount(7'd3);
        send_edge(6'd0, 6'd1); send_edge(6'd1, 6'd2); send_edge(6'd2, 6'd0);
        send_edge(6'd1, 6'd1); send_edge(6'd0, 6'd63); send_compute(); drain();
        set_vcount(7'd4);
        for (int i = 0; i < 4; i++)
            for (int j = i + 1; j < 4; j++) send_edge(6'(i), 6'(j));
        send_compute(); drain();
    endtask

    // register change while loading keeps the store
    task automatic test_cfg_midload();
        set_vcount(7'd6);
        send_edge(6'd0, 6'd4); send_edge(6'd4, 6'd3); send_edge(6'd1, 6'd2);
        drain();
        set_vcount(7'd4);
        send_edge(6'd2, 6'd0); send_compute(); drain();
    endtask

    // random graphs at small sizes, with noise requests
    task automatic test_random(int n_items);
        int sent;
        int n_edges;
        int vc;
        logic [5:0] a;
        logic [5:0] b;
        sent = 0;
        while (sent < n_items) begin
            vc = ($urandom_range(19) == 0) ? $urandom_range(1, 0) : $urandom_range(8, 2);
            set_vcount(7'(vc));
            n_edges = $urandom_range(24, 2);
            for (int k = 0; k < n_edges; k++) begin
                if ($urandom_range(99) < 15 || vc < 2) begin
                    a = 6'($urandom_range(63));
                    b = ($urandom_range(3) == 0) ? a : 6'($urandom_range(63));
                end else begin
                    a = 6'($urandom_range(vc - 1));
                    b = 6'($urandom_range(vc - 1));
                end
                send_edge(a, b);
            end
            send_compute();
            sent += n_edges + 1;
            drain();
        end
    endtask

    initial begin
        foreach (lap_shadow[i]) lap_shadow[i] = '0;
        vcount_shadow = 7'd1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_trivial();
        test_graphs();
        test_cfg_midload();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(360);
        send_idle_pct = 78; recv_stall_pct = 0;  test_random(360);
        send_idle_pct = 0;  recv_stall_pct = 78; test_random(360);
        send_idle_pct = 12; recv_stall_pct = 12; test_random(360);
        drain();
        repeat (50) @(posedge aclk);
        if (errors == 0 && count_queue.size() == 0)
            $display("spanning_tree_count_mod_prime_unit_tb: clean");
        else
            $display("spanning_tree_count_mod_prime_unit_tb: errors");
        $finish;
    end

    // run limit
    initial begin
        #480000000;
        $display("spanning_tree_count_mod_prime_unit_tb: errors");
        $finish;
    end

endmodule

FILE: spanning_tree_count_mod_prime_unit.f
+incdir+hdl
hdl/stc_pkg.sv
hdl/stc_lap_ram.sv
hdl/stc_mulmod.sv
hdl/spanning_tree_count_mod_prime_unit.sv
tb/spanning_tree_count_mod_prime_unit_tb.sv
